// ----- rtl/core/sof_pkg.sv -----
// Shared types and codes for the start-of-frame / length / checksum deframer.
// Used by the front and back modules and the top level.
`default_nettype none
package sof_pkg;
	// Ring size in bytes; the 10-bit positions on the ports are sized for it.
	localparam int DEPTH = 1024;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_FIND  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_FOUND   = 3'd2,
		ST_NOFRAME = 3'd3,
		ST_READ    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_TAG,
		BK_LEN0,
		BK_LEN1,
		BK_SUM,
		BK_READ,
		BK_DONE
	} back_state_t;

	// One classified command between the front and the back.
	typedef struct packed {
		opcode_t     op;
		logic [7:0]  data;
		logic [15:0] index;
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/sof_front.sv -----
// Front part: accepts commands, drops opcode 3, and queues the rest.
// Depends on sof_pkg.
`default_nettype none
module sof_front #(
	parameter int QDEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  wire [1:0]        opcode,
	input  wire [7:0]        data_byte,
	input  wire [15:0]       index,
	output sof_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  wire              cmd_take
);
	import sof_pkg::*;
	localparam int PW = $clog2(QDEPTH);

	cmd_t           q_mem [QDEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;
	logic           put;

	assign full      = (cnt_q == (PW+1)'(QDEPTH));
	assign put       = push && !full && (opcode != OP_NONE);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (put) q_mem[wr_q] <= '{op: opcode_t'(opcode), data: data_byte, index: index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (put) wr_q <= (wr_q == PW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (cmd_take) rd_q <= (rd_q == PW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(put) - (PW+1)'(cmd_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take from empty command queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (PW+1)'(QDEPTH))
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(put && !cmd_take) |=> cmd_valid)
		else $error("queued command lost");
endmodule
`default_nettype wire

// ----- rtl/core/sof_back.sv -----
// Back part: ring memory, pointers, frame scanner and one-entry result register.
// Depends on sof_pkg.
`default_nettype none
module sof_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [7:0]        start_tag,
	input  wire sof_pkg::cmd_t cmd,
	input  wire              cmd_valid,
	output logic             cmd_take,
	output logic             res_valid,
	input  wire              res_take,
	output logic [2:0]       status,
	output logic [9:0]       frame_start,
	output logic [9:0]       frame_length,
	output logic [7:0]       read_byte,
	output logic [9:0]       buffered_count
);
	import sof_pkg::*;
	localparam int AW = $clog2(DEPTH);

	logic [7:0]     ring [DEPTH];
	logic [AW-1:0]  wp_q, sp_q, cur_q, raddr;
	logic [7:0]     rdata_q;
	logic [15:0]    len_q;
	logic [15:0]    i_q;
	logic [7:0]     sum_q;
	logic [7:0]     len_lo_q;
	back_state_t    st_q, st_d;
	logic           res_full_q;
	logic [AW-1:0]  held, held_st;
	logic           busy_ok;
	logic           do_store;
	logic           rd_issue;
	// result builder
	logic           fin;
	status_t        fin_st;
	logic [AW-1:0]  sp_next;
	logic           fin_found_q;
	logic [AW-1:0]  found_start_q;
	logic [15:0]    found_len_q;
	logic           sum_hit;

	assign held = wp_q - sp_q;
	assign res_valid = res_full_q;
	// The result register must be free before a command finishes.
	assign busy_ok = !res_full_q || res_take;
	// A store into a full ring leaves the memory untouched.
	assign do_store = (st_q == BK_IDLE) && cmd_valid && busy_ok && cmd.op == OP_STORE
		&& held != AW'(DEPTH-1);

	// Read address: tag/length/sum walk uses cur_q; read command its index.
	// A bad length or a failed checksum pass restarts the walk at the new scan position.
	always_comb begin
		raddr = cur_q;
		if (st_q == BK_IDLE) raddr = (cmd.op == OP_READ) ? cmd.index[AW-1:0] : sp_q;
		else if (st_q == BK_SUM && st_d == BK_TAG) raddr = sp_next;
	end

	always_ff @(posedge clk) begin
		if (do_store) ring[wp_q] <= cmd.data;
		rdata_q <= ring[raddr];
	end

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (cmd_valid && busy_ok) begin
				unique case (cmd.op)
					OP_FIND:  st_d = (held == '0) ? BK_DONE : BK_TAG;
					OP_READ:  st_d = BK_READ;
					default:  st_d = BK_IDLE;
				endcase
			end
			BK_TAG: begin
				if (rdata_q != start_tag) st_d = (cur_q == wp_q) ? BK_DONE : BK_TAG;
				else if (held < AW'(3)) st_d = BK_DONE;
				else st_d = BK_LEN0;
			end
			BK_LEN0: st_d = BK_LEN1;
			BK_LEN1: st_d = BK_SUM;
			BK_SUM: begin
				if (len_q < 16'd4 || len_q > 16'(DEPTH-1)) st_d = (sp_q + 1'b1 == wp_q) ? BK_DONE : BK_TAG;
				else if ({{(16-AW){1'b0}}, held} < len_q) st_d = BK_DONE;
				else if (i_q == len_q) st_d = ((sum_q + rdata_q) == 8'd0 || len_q == 16'd0) ? BK_DONE
					: ((sp_q + 1'b1 == wp_q) ? BK_DONE : BK_TAG);
				else st_d = BK_SUM;
			end
			BK_READ: st_d = BK_IDLE;
			BK_DONE: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	assign held_st = held;

	// Outputs of the sequencer
	always_comb begin
		cmd_take = 1'b0;
		fin = 1'b0;
		fin_st = ST_NOFRAME;
		sp_next = sp_q;
		rd_issue = 1'b0;
		unique case (st_q)
			BK_IDLE: if (cmd_valid && busy_ok && cmd.op == OP_STORE) begin
				cmd_take = 1'b1;
				fin = 1'b1;
				fin_st = (held_st == AW'(DEPTH-1)) ? ST_DROPPED : ST_STORED;
			end
			BK_TAG: if (rdata_q != start_tag) sp_next = cur_q;
			BK_SUM: begin
				if (len_q < 16'd4 || len_q > 16'(DEPTH-1)) sp_next = sp_q + 1'b1;
				else if ({{(16-AW){1'b0}}, held} < len_q) sp_next = sp_q;
				else if (i_q == len_q) begin
					if ((sum_q + rdata_q) == 8'd0) sp_next = sp_q + len_q[AW-1:0];
					else sp_next = sp_q + 1'b1;
				end
			end
			BK_READ: begin
				cmd_take = 1'b1;
				fin = 1'b1;
				fin_st = ST_READ;
				rd_issue = 1'b1;
			end
			BK_DONE: begin
				cmd_take = 1'b1;
				fin = 1'b1;
				fin_st = (fin_found_q) ? ST_FOUND : ST_NOFRAME;
			end
			default: ;
		endcase
	end

	assign sum_hit = (st_q == BK_SUM) && !(len_q < 16'd4 || len_q > 16'(DEPTH-1))
		&& !({{(16-AW){1'b0}}, held} < len_q) && (i_q == len_q) && ((sum_q + rdata_q) == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; wp_q <= '0; sp_q <= '0; res_full_q <= 1'b0;
			fin_found_q <= 1'b0;
		end else begin
			st_q <= st_d;
			sp_q <= sp_next;
			if (do_store) wp_q <= wp_q + 1'b1;
			if (fin) res_full_q <= 1'b1;
			else if (res_take) res_full_q <= 1'b0;
			if (st_q == BK_IDLE) fin_found_q <= 1'b0;
			else if (sum_hit) fin_found_q <= 1'b1;
		end
	end

	// Scan datapath. The ring is read one byte a cycle with registered data,
	// so during a scan cur_q runs one address ahead of rdata_q.
	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: cur_q <= sp_q + 1'b1;
			BK_TAG: begin
				if (rdata_q != start_tag) cur_q <= cur_q + 1'b1;
				else begin
					sum_q <= rdata_q;
					cur_q <= cur_q + 1'b1;
				end
			end
			BK_LEN0: begin
				len_lo_q <= rdata_q;
				sum_q <= sum_q + rdata_q;
				cur_q <= cur_q + 1'b1;
			end
			BK_LEN1: begin
				len_q <= {rdata_q, len_lo_q};
				sum_q <= sum_q + rdata_q;
				i_q <= 16'd4;
				cur_q <= cur_q + 1'b1;
			end
			BK_SUM: begin
				if (st_d == BK_TAG) cur_q <= sp_next + 1'b1;
				else begin
					sum_q <= sum_q + rdata_q;
					i_q <= i_q + 1'b1;
					cur_q <= cur_q + 1'b1;
				end
				if (sum_hit) begin
					found_start_q <= sp_q;
					found_len_q <= len_q;
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fin) begin
			status <= 3'(fin_st);
			frame_start <= '0;
			frame_length <= '0;
			read_byte <= '0;
			buffered_count <= 10'(held + AW'(do_store));
			if (rd_issue) read_byte <= rdata_q;
			if (st_q == BK_DONE && fin_found_q) begin
				frame_start <= 10'(found_start_q);
				frame_length <= 10'(found_len_q);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fin |-> busy_ok || st_q != BK_IDLE)
		else $error("result register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("command taken while none waits");
	assert property (@(posedge clk) disable iff (!arst_n) (st_q == BK_READ) |=> st_q == BK_IDLE)
		else $error("read did not complete");
endmodule
`default_nettype wire

// ----- rtl/core/sof_length_checksum_deframer.sv -----
// Top level of the start-of-frame / length / checksum deframer.
// Instantiates sof_front and sof_back; depends on sof_pkg.
//
// Commands enter through a queue interface (push/full) and results leave
// through one (empty/pop). Opcode 0 stores a byte, 1 finds the next frame,
// 2 reads one ring byte; opcode 3 is accepted and ignored.
// A command is written into the command queue before the back part sees it.
// A store is handled in the back part's idle state; a read passes through BK_READ
// after the registered memory read. A find walks the ring one byte a cycle through the
// single read port: it skips bytes that are not the tag, reads the tag and both length
// bytes, sums the frame for each checksum pass, and then takes the command and
// writes the result in BK_DONE.
// A two-entry command queue decouples input from the scanner; a one-entry
// result register holds the finished result, and a stalled pop stops the
// back part while the queue still takes commands until it is full.
// Reset clears both pointers, the queue and the result register; ring contents
// are undefined until written. The user writes start_tag through cfg_we/cfg_data
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module sof_length_checksum_deframer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_data,
	input  wire        push,
	output logic       full,
	input  wire [1:0]  opcode,
	input  wire [7:0]  data_byte,
	input  wire [9:0]  read_index,
	output logic       empty,
	input  wire        pop,
	output logic [2:0] status,
	output logic [9:0] frame_start,
	output logic [9:0] frame_length,
	output logic [7:0] read_byte,
	output logic [9:0] buffered_count
);
	import sof_pkg::*;

	logic [7:0] start_tag_q;
	cmd_t       cmd;
	logic       cmd_valid, cmd_take, res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_tag_q <= '0;
		else if (cfg_we) start_tag_q <= cfg_data;
	end

	sof_front #(.QDEPTH(2)) u_front (
		.clk, .arst_n, .push, .full, .opcode, .data_byte,
		.index({6'd0, read_index}), .cmd, .cmd_valid, .cmd_take
	);

	sof_back u_back (
		.clk, .arst_n, .start_tag(start_tag_q), .cmd, .cmd_valid, .cmd_take,
		.res_valid, .res_take(pop && res_valid), .status, .frame_start,
		.frame_length, .read_byte, .buffered_count
	);

	assign empty = !res_valid;
endmodule
`default_nettype wire

// ----- tb/sv/tb_sof_length_checksum_deframer.sv -----
// Self-checking testbench for sof_length_checksum_deframer.
// It keeps its own copy of the ring, the pointers and the start tag and compares every
// result transaction with its prediction. Depends on sof_pkg and the RTL of the deframer.
module tb_sof_length_checksum_deframer;
	timeunit 1ns;
	timeprecision 1ps;
	import sof_pkg::*;

	localparam int RING = 1024;

	typedef struct packed {
		status_t    st;
		logic [9:0] fstart;
		logic [9:0] flen;
		logic [7:0] rbyte;
		logic [9:0] count;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] opcode = 2'd0;
	logic [7:0] data_byte = 8'd0;
	logic [9:0] read_index = 10'd0;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] status;
	logic [9:0] frame_start;
	logic [9:0] frame_length;
	logic [7:0] read_byte;
	logic [9:0] buffered_count;

	// Predicted state of the deframer.
	logic [7:0] ring_copy [RING];
	bit         ring_written [RING];
	int         wr_pos;
	int         scan_pos;
	logic [7:0] tag_copy;

	reply_t     replies_due [$];
	int         errors;
	int         sent_items;
	int         frames_found;
	int         drops_seen;
	bit         no_gaps;

	sof_length_checksum_deframer uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .opcode(opcode), .data_byte(data_byte),
		.read_index(read_index), .empty(empty), .pop(pop), .status(status),
		.frame_start(frame_start), .frame_length(frame_length),
		.read_byte(read_byte), .buffered_count(buffered_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int held_bytes();
		return (wr_pos >= scan_pos) ? wr_pos - scan_pos : wr_pos + RING - scan_pos;
	endfunction

	function automatic logic [7:0] ring_at(int offset);
		return ring_copy[(scan_pos + offset) % RING];
	endfunction

	// Walks the ring the way the scanner does; returns 1 when a valid frame is found.
	function automatic bit scan_for_frame(output int fstart, output int flen);
		int avail;
		int len;
		logic [7:0] sum;
		fstart = 0;
		flen = 0;
		while (wr_pos != scan_pos) begin
			if (ring_at(0) != tag_copy) begin
				scan_pos = (scan_pos + 1) % RING;
				continue;
			end
			avail = held_bytes();
			if (avail < 3)
				return 1'b0;
			len = {ring_at(2), ring_at(1)};
			if (len < 4 || len > RING - 1) begin
				scan_pos = (scan_pos + 1) % RING;
				continue;
			end
			if (avail < len)
				return 1'b0;
			sum = 8'd0;
			for (int i = 0; i < len; i++)
				sum += ring_at(i);
			if (sum != 8'd0) begin
				scan_pos = (scan_pos + 1) % RING;
				continue;
			end
			fstart = scan_pos;
			flen = len;
			scan_pos = (scan_pos + len) % RING;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void predict_reply(opcode_t op, logic [7:0] d, logic [9:0] ri);
		reply_t r;
		int fs;
		int fl;
		r = '0;
		case (op)
			OP_STORE: begin
				if (held_bytes() >= RING - 1) begin
					r.st = ST_DROPPED;
				end else begin
					ring_copy[wr_pos] = d;
					ring_written[wr_pos] = 1'b1;
					wr_pos = (wr_pos + 1) % RING;
					r.st = ST_STORED;
				end
			end
			OP_FIND: begin
				if (scan_for_frame(fs, fl)) begin
					r.st = ST_FOUND;
					r.fstart = fs[9:0];
					r.flen = fl[9:0];
				end else begin
					r.st = ST_NOFRAME;
				end
			end
			OP_READ: begin
				r.st = ST_READ;
				r.rbyte = ring_copy[ri];
			end
			default: return;
		endcase
		r.count = 10'(held_bytes());
		replies_due.push_back(r);
	endfunction

	// Random gap before the next command: mostly none, sometimes short, rarely long.
	task automatic idle_gap();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (no_gaps || pick < 65)
			return;
		n = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sends one command; returns at the edge where it was accepted.
	task automatic send_cmd(opcode_t op, logic [7:0] d, logic [9:0] ri);
		idle_gap();
		push <= 1'b1;
		opcode <= op;
		data_byte <= d;
		read_index <= ri;
		do
			@(posedge clk);
		while (full);
		predict_reply(op, d, ri);
		sent_items++;
	endtask

	task automatic store_byte(logic [7:0] b);
		send_cmd(OP_STORE, b, 10'($urandom));
	endtask

	task automatic find_frame();
		send_cmd(OP_FIND, 8'($urandom), 10'($urandom));
	endtask

	task automatic read_written();
		int idx;
		idx = $urandom_range(RING - 1);
		while (!ring_written[idx])
			idx = (idx + 1) % RING;
		send_cmd(OP_READ, 8'($urandom), idx[9:0]);
	endtask

	// Frame of total length len; bad_sum spoils the checksum. Out-of-range lengths
	// only send the header and a few bytes.
	task automatic store_frame(int len, bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		store_byte(tag_copy);
		store_byte(len[7:0]);
		store_byte(len[15:8]);
		if (len < 4 || len > RING - 1) begin
			repeat ($urandom_range(0, 3)) store_byte(8'($urandom));
			return;
		end
		sum = tag_copy + len[7:0] + len[15:8];
		for (int i = 3; i < len - 1; i++) begin
			b = 8'($urandom);
			sum += b;
			store_byte(b);
		end
		store_byte(bad_sum ? 8'(1 - sum) : 8'(0 - sum));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_tag(logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tag_copy = value;
	endtask

	// Result side: pop with random stalls, occasionally long ones.
	initial begin
		int pick;
		forever begin
			@(posedge clk);
			pick = $urandom_range(99);
			if (no_gaps || pick < 70) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				if (pick > 96)
					repeat ($urandom_range(10, 50)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && pop && !empty) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result, actual st=%0d start=%0d len=%0d byte=%0d cnt=%0d",
					$time, status, frame_start, frame_length, read_byte, buffered_count);
				errors++;
			end else begin
				e = replies_due.pop_front();
				if (e.st !== status || e.fstart !== frame_start || e.flen !== frame_length
						|| e.rbyte !== read_byte || e.count !== buffered_count) begin
					$display("%0t: mismatch expected st=%0d start=%0d len=%0d byte=%0d cnt=%0d",
						$time, e.st, e.fstart, e.flen, e.rbyte, e.count);
					$display("%0t:          actual   st=%0d start=%0d len=%0d byte=%0d cnt=%0d",
						$time, status, frame_start, frame_length, read_byte, buffered_count);
					errors++;
				end
				if (e.st == ST_FOUND)
					frames_found++;
				if (e.st == ST_DROPPED)
					drops_seen++;
			end
		end
	end

	task automatic test_basic_frames();
		find_frame();
		store_frame(4, 1'b0);
		find_frame();
		store_byte(tag_copy);
		find_frame();
		store_byte(8'h03);
		store_byte(8'h00);
		find_frame();
		store_frame(5, 1'b1);
		store_frame(6, 1'b0);
		find_frame();
		read_written();
		send_cmd(OP_NONE, 8'hFF, 10'h3FF);
		find_frame();
	endtask

	task automatic test_full_ring();
		wait_idle();
		no_gaps = 1'b1;
		store_frame(RING - 1, 1'b0);
		no_gaps = 1'b0;
		store_byte(8'hFF);
		store_byte(8'h00);
		find_frame();
		read_written();
		store_frame(16'hFFFF, 1'b0);
		store_frame(RING, 1'b0);
		find_frame();
	endtask

	task automatic test_random_traffic(int n_items);
		int pick;
		int stop_at;
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			if ((sent_items / 150) % 2 == 1)
				no_gaps = 1'b0;
			pick = $urandom_range(99);
			if (held_bytes() > 700 || pick < 15)
				find_frame();
			else if (pick < 60)
				store_frame(($urandom_range(19) == 0) ? $urandom_range(4, 120)
					: $urandom_range(4, 12), 1'b0);
			else if (pick < 68)
				store_frame($urandom_range(4, 12), 1'b1);
			else if (pick < 74)
				store_frame(($urandom_range(1) == 0) ? $urandom_range(0, 3)
					: $urandom_range(RING, 65535), 1'b0);
			else if (pick < 86)
				store_byte(8'($urandom));
			else if (pick < 96)
				read_written();
			else
				send_cmd(OP_NONE, 8'($urandom), 10'($urandom));
		end
		while (held_bytes() > 0 && $urandom_range(3) != 0)
			find_frame();
	endtask

	initial begin
		errors = 0;
		sent_items = 0;
		frames_found = 0;
		drops_seen = 0;
		no_gaps = 1'b0;
		wr_pos = 0;
		scan_pos = 0;
		tag_copy = 8'd0;
		foreach (ring_written[i])
			ring_written[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		write_tag(8'hFF);
		test_basic_frames();
		test_full_ring();
		write_tag(8'hA5);
		test_random_traffic(25);
		write_tag(8'h00);
		test_random_traffic(20);
		write_tag(8'($urandom));
		test_random_traffic(25);
		wait_idle();

		$display("Covered %0d commands over several start tags: %0d frames found, %0d drops.",
			sent_items, frames_found, drops_seen);
		if (errors == 0)
			$display("tb_sof_length_checksum_deframer: PASS");
		else
			$display("tb_sof_length_checksum_deframer: FAIL");
		$finish;
	end

	initial begin
		#8ms;
		$display("Timeout with %0d results outstanding.", replies_due.size());
		$display("tb_sof_length_checksum_deframer: FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/sof_pkg.sv
rtl/core/sof_front.sv
rtl/core/sof_back.sv
rtl/core/sof_length_checksum_deframer.sv
tb/sv/tb_sof_length_checksum_deframer.sv
